// ===== rtl/mtk_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtk_pkg: shared types, constants and symbol tables
// Event codes, key codes, reset values and the multi-tap letter ranges used
// by the keypad text entry block.
// ----------------------------------------------------------------------------
package mtk_pkg;

  // Defaults and reset values
  localparam int unsigned BUFFER_DEPTH_DEF = 10;
  localparam logic [3:0]  MAX_CHARS_RST    = 4'd10;
  localparam logic [15:0] TIMEOUT_RST      = 16'd10000;
  localparam logic [3:0]  ROW0_CHARS       = 4'd10;
  localparam logic [15:0] TICK_SAT         = 16'hFFFF;

  // Event codes
  localparam logic [2:0] FN_TICK    = 3'd0;
  localparam logic [2:0] FN_PRESS   = 3'd1;
  localparam logic [2:0] FN_RELEASE = 3'd2;
  localparam logic [2:0] FN_START   = 3'd3;
  localparam logic [2:0] FN_READ    = 3'd4;

  // Key codes
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_STAR      = 4'd10;
  localparam logic [3:0] KEY_HASH      = 4'd11;
  localparam logic [3:0] KEY_NONE      = 4'd15;

  // Configuration register indices
  localparam logic [1:0] CFG_MAX_CHARS = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd1;

  // ASCII digit zero
  localparam logic [6:0] ZERO_CODE = 7'h30;

  // One input item
  typedef struct packed {
    logic [2:0] func;
    logic [3:0] key;
    logic [3:0] read_index;
  } item_t;

  // One result item
  typedef struct packed {
    logic       char_written;
    logic [3:0] char_index;
    logic [6:0] char_code;
    logic       display_row;
    logic       active;
    logic       finished;
    logic [3:0] char_count;
    logic [6:0] read_data;
  } result_t;

  // Buffer write request
  typedef struct packed {
    logic       en;
    logic [3:0] addr;
    logic [6:0] data;
  } buf_wr_t;

  // First symbol of a digit key
  function automatic logic [6:0] first_sym(input logic [3:0] k);
    logic [6:0] s;
    case (k)
      4'd0:    s = 7'h20;
      4'd1:    s = 7'h31;
      4'd2:    s = 7'h41;
      4'd3:    s = 7'h44;
      4'd4:    s = 7'h47;
      4'd5:    s = 7'h4A;
      4'd6:    s = 7'h4D;
      4'd7:    s = 7'h50;
      4'd8:    s = 7'h54;
      4'd9:    s = 7'h57;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // Last letter of a digit key; key 1 has no letters
  function automatic logic [6:0] last_sym(input logic [3:0] k);
    logic [6:0] s;
    case (k)
      4'd0:    s = 7'h20;
      4'd2:    s = 7'h43;
      4'd3:    s = 7'h46;
      4'd4:    s = 7'h49;
      4'd5:    s = 7'h4C;
      4'd6:    s = 7'h4F;
      4'd7:    s = 7'h53;
      4'd8:    s = 7'h56;
      4'd9:    s = 7'h5A;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mtk_text_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtk_text_buf: generic RAM
// One write port and one read port with registered read data; the read data
// holds while the read enable is low.
// ----------------------------------------------------------------------------
module mtk_text_buf #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; callers only request in-range positions
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, old data on a same-edge write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mtk_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtk_engine: entry state and per-event update
// Holds the entry phase, character count, last key, tap step and tick
// counter, and works out the result of one event in a single pass.
// ----------------------------------------------------------------------------
module mtk_engine
  import mtk_pkg::*;
#(
  parameter int unsigned DEPTH = BUFFER_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire item_t       item,
  input  wire logic [3:0]  max_chars,
  input  wire logic [15:0] timeout_ticks,
  input  wire logic [6:0]  rd_data,
  output buf_wr_t          wr,
  output result_t          result
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_HELD
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  count, count_next;
  logic [3:0]  last_key, last_key_next;
  logic [2:0]  press_step, press_step_next;
  logic [15:0] tick_count, tick_count_next;

  logic [3:0]  eff_max;
  logic [15:0] tick_inc;
  logic [3:0]  ek_key;
  logic [15:0] ek_tick;
  logic        new_char;
  logic [4:0]  count_inc;
  logic [2:0]  step;
  logic [6:0]  f_sym, l_sym;
  logic [7:0]  sym_sum;
  logic        wrap;
  logic [6:0]  code;
  logic [2:0]  step_after;
  logic [4:0]  pos;
  logic        in_buf;
  logic        written, fin;
  logic [6:0]  rdata;

  // Effective maximum and saturating tick
  assign eff_max  = ({2'b00, max_chars} > 6'(DEPTH)) ? 4'(DEPTH) : max_chars;
  assign tick_inc = (tick_count != TICK_SAT) ? tick_count + 16'd1 : tick_count;

  // Symbol placement shared by presses and the full-buffer timeout
  assign ek_key     = (item.func == FN_TICK) ? last_key : item.key;
  assign ek_tick    = (item.func == FN_TICK) ? tick_inc : tick_count;
  assign new_char   = (ek_key != last_key) || (ek_tick > timeout_ticks);
  assign count_inc  = {1'b0, count} + {4'd0, new_char};
  assign step       = new_char ? 3'd0 : press_step;
  assign f_sym      = first_sym(ek_key);
  assign l_sym      = last_sym(ek_key);
  assign sym_sum    = {1'b0, f_sym} + {5'd0, step};
  assign wrap       = sym_sum > {1'b0, l_sym};
  assign code       = wrap ? ZERO_CODE + {3'd0, ek_key} : sym_sum[6:0];
  assign step_after = wrap ? 3'd0 : step + 3'd1;
  assign pos        = (count_inc == 5'd0) ? 5'd0 : count_inc - 5'd1;
  assign in_buf     = {1'b0, pos} < 6'(DEPTH);

  // Event decode
  always_comb begin
    phase_next      = phase;
    count_next      = count;
    last_key_next   = last_key;
    press_step_next = press_step;
    tick_count_next = tick_count;
    written         = 1'b0;
    fin             = 1'b0;
    rdata           = '0;
    unique case (item.func)
      FN_TICK: begin
        tick_count_next = tick_inc;
        if (phase == PH_WAIT && tick_inc > timeout_ticks && count == eff_max) begin
          if (last_key <= KEY_DIGIT_MAX) begin
            tick_count_next = '0;
            press_step_next = step_after;
            written         = in_buf;
          end
          phase_next = PH_IDLE;
          fin        = 1'b1;
        end
      end
      FN_PRESS: begin
        if (phase == PH_WAIT) begin
          if (item.key == KEY_STAR || item.key == KEY_HASH) begin
            phase_next = PH_IDLE;
            fin        = 1'b1;
          end else if (item.key <= KEY_DIGIT_MAX) begin
            last_key_next   = item.key;
            tick_count_next = '0;
            press_step_next = step_after;
            written         = in_buf;
            if (count_inc > {1'b0, eff_max}) begin
              count_next = 4'(count_inc - 5'd1);
              phase_next = PH_IDLE;
              fin        = 1'b1;
            end else begin
              count_next = count_inc[3:0];
              phase_next = PH_HELD;
            end
          end
        end
      end
      FN_RELEASE: begin
        if (phase == PH_HELD) begin
          phase_next = PH_WAIT;
        end
      end
      FN_START: begin
        count_next    = '0;
        last_key_next = KEY_NONE;
        phase_next    = PH_WAIT;
      end
      FN_READ: begin
        rdata = rd_data;
      end
      default: begin
      end
    endcase
  end

  // Buffer write and result
  assign wr.en   = fire && written;
  assign wr.addr = pos[3:0];
  assign wr.data = code;

  assign result.char_written = written;
  assign result.char_index   = written ? pos[3:0] : 4'd0;
  assign result.char_code    = written ? code : 7'd0;
  assign result.display_row  = (max_chars != ROW0_CHARS);
  assign result.active       = (phase_next != PH_IDLE);
  assign result.finished     = fin;
  assign result.char_count   = count_next;
  assign result.read_data    = rdata;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      count      <= '0;
      last_key   <= KEY_NONE;
      press_step <= '0;
      tick_count <= '0;
    end else if (fire) begin
      phase      <= phase_next;
      count      <= count_next;
      last_key   <= last_key_next;
      press_step <= press_step_next;
      tick_count <= tick_count_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/multi_tap_keypad_text_entry.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_tap_keypad_text_entry: multi-tap keypad text entry
// Top level: configuration registers, input register, engine and buffer,
// result register.
// ----------------------------------------------------------------------------
// Each event transfer (tick, press, release, start, read) yields exactly one
// result. The block takes one event per cycle while the output side is ready.
// An event is held in the input register while the engine updates the entry
// state and the character buffer in one pass, and the result register loads
// when it is free, so the result is offered once it has passed the input
// register and the result register. The buffer read port is loaded at the
// event transfer itself, with a bypass for a character written at that same
// edge. While a result waits to be taken the input register still takes one
// event and then holds it; throughput is one event per clock whenever the
// output side is ready. The buffer needs no clearing after reset; a read of a
// position never written since reset returns an unspecified code. Configuration
// writes take effect at once and are meant to be made while the block is idle.
// ----------------------------------------------------------------------------
module multi_tap_keypad_text_entry
  import mtk_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // event channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  func,
  input  wire logic [3:0]  key,
  input  wire logic [3:0]  read_index,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             char_written,
  output logic      [3:0]  char_index,
  output logic      [6:0]  char_code,
  output logic             display_row,
  output logic             active,
  output logic             finished,
  output logic      [3:0]  char_count,
  output logic      [6:0]  read_data
);

  localparam int unsigned ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic [3:0]  max_chars;
  logic [15:0] timeout_ticks;
  logic        in_full;
  item_t       item_q;
  logic        advance;
  logic        in_take;
  logic        idx_ok;
  logic        rd_en;
  logic        rd_in_range;
  logic        byp_hit;
  logic [6:0]  byp_data;
  logic [6:0]  ram_q;
  buf_wr_t     wr;
  logic [6:0]  rd_data;
  result_t     result;
  result_t     res_q;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars     <= MAX_CHARS_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_CHARS: max_chars     <= cfg_data[3:0];
        CFG_TIMEOUT:   timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the engine advances when the result register is free
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;
  assign in_take  = in_valid && in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  // Buffer read is started at the transfer; same-edge write is bypassed
  assign idx_ok = {2'b00, read_index} < 6'(BUFFER_DEPTH);
  assign rd_en  = in_take && idx_ok;

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_q.func       <= func;
      item_q.key        <= key;
      item_q.read_index <= read_index;
      rd_in_range       <= idx_ok;
      byp_hit           <= wr.en && (wr.addr == read_index);
      byp_data          <= wr.data;
    end
  end

  assign rd_data = !rd_in_range ? '0 : (byp_hit ? byp_data : ram_q);

  mtk_engine #(
    .DEPTH(BUFFER_DEPTH)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .fire         (advance),
    .item         (item_q),
    .max_chars    (max_chars),
    .timeout_ticks(timeout_ticks),
    .rd_data      (rd_data),
    .wr           (wr),
    .result       (result)
  );

  mtk_text_buf #(
    .WIDTH (7),
    .DEPTH (BUFFER_DEPTH),
    .ADDR_W(ADDR_W)
  ) u_text_buf (
    .clk  (clk),
    .we   (wr.en),
    .waddr(ADDR_W'(wr.addr)),
    .wdata(wr.data),
    .re   (rd_en),
    .raddr(ADDR_W'(read_index)),
    .rdata(ram_q)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign char_written = res_q.char_written;
  assign char_index   = res_q.char_index;
  assign char_code    = res_q.char_code;
  assign display_row  = res_q.display_row;
  assign active       = res_q.active;
  assign finished     = res_q.finished;
  assign char_count   = res_q.char_count;
  assign read_data    = res_q.read_data;

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad text entry testbench
// Drives tick, press, release, start and read events through the event
// channel, predicts each result from an independent model of the multi-tap
// entry logic and compares every field of every result transfer.
// ----------------------------------------------------------------------------
module testbench
  import mtk_pkg::*;
;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 750;
  localparam int PHASES       = 8;

  typedef enum logic [1:0] {ENTRY_IDLE, ENTRY_WAIT, ENTRY_HELD} entry_phase_t;

  // DUT connections, all inputs known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_MAX_CHARS;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  func = FN_TICK;
  logic [3:0]  key = '0;
  logic [3:0]  read_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        char_written;
  logic [3:0]  char_index;
  logic [6:0]  char_code;
  logic        display_row;
  logic        active;
  logic        finished;
  logic [3:0]  char_count;
  logic [6:0]  read_data;

  multi_tap_keypad_text_entry i_dut (.*);

  // Multi-tap letter ranges per digit key (key 1 has no letters)
  logic [6:0] letter_first [10] = '{7'h20, 7'h31, 7'h41, 7'h44, 7'h47,
                                    7'h4A, 7'h4D, 7'h50, 7'h54, 7'h57};
  logic [6:0] letter_last  [10] = '{7'h20, 7'h00, 7'h43, 7'h46, 7'h49,
                                    7'h4C, 7'h4F, 7'h53, 7'h56, 7'h5A};

  // Predicted entry state and register copies
  entry_phase_t entry_phase;
  logic [6:0]   text_mem [10];
  logic [9:0]   written_mask;
  logic [3:0]   char_total;
  logic [3:0]   prev_key;
  logic [2:0]   tap_step;
  logic [15:0]  tick_total;
  logic [3:0]   max_chars_reg;
  logic [15:0]  timeout_reg;
  logic         ignored_item;

  result_t pending_results [$];
  result_t want;
  int      mismatches = 0;
  int      live_items = 0;
  int      stall_cycles = 0;
  logic    steady = 1'b0;

  // Clock
  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void reset_model();
    entry_phase   = ENTRY_IDLE;
    written_mask  = '0;
    char_total    = '0;
    prev_key      = KEY_NONE;
    tap_step      = '0;
    tick_total    = '0;
    max_chars_reg = MAX_CHARS_RST;
    timeout_reg   = TIMEOUT_RST;
    foreach (text_mem[i]) text_mem[i] = '0;
  endfunction

  // One tap of a digit key: new character or next symbol of the current one
  function automatic void tap_key(input logic [3:0] k, output logic [3:0] pos,
                                  output logic [6:0] code);
    logic [7:0] sum;
    if (k != prev_key || tick_total > timeout_reg) begin
      char_total = char_total + 4'd1;
      tap_step   = '0;
    end
    prev_key   = k;
    tick_total = '0;
    sum = {1'b0, letter_first[k]} + {5'd0, tap_step};
    if (sum > {1'b0, letter_last[k]}) begin
      tap_step = '0;
      code     = ZERO_CODE + {3'd0, k};
    end else begin
      code     = sum[6:0];
      tap_step = tap_step + 3'd1;
    end
    pos = (char_total == 4'd0) ? 4'd0 : char_total - 4'd1;
  endfunction

  // Positions past the buffer end are dropped and not reported
  function automatic void store_char(input logic [3:0] pos, input logic [6:0] code,
                                     inout result_t r);
    if (pos < BUFFER_DEPTH_DEF) begin
      text_mem[pos]     = code;
      written_mask[pos] = 1'b1;
      r.char_written    = 1'b1;
      r.char_index      = pos;
      r.char_code       = code;
    end
  endfunction

  function automatic result_t keypad_step(input logic [2:0] f, input logic [3:0] k,
                                          input logic [3:0] ri);
    result_t    r;
    logic [3:0] lim, pos, kept;
    logic [6:0] code;
    r   = '0;
    lim = (max_chars_reg > BUFFER_DEPTH_DEF) ? 4'(BUFFER_DEPTH_DEF) : max_chars_reg;
    ignored_item = 1'b0;
    case (f)
      FN_TICK: begin
        if (tick_total != TICK_SAT) tick_total = tick_total + 16'd1;
        // full buffer and timed out: close the entry
        if (entry_phase == ENTRY_WAIT && tick_total > timeout_reg && char_total == lim) begin
          if (prev_key <= KEY_DIGIT_MAX) begin
            kept = char_total;
            tap_key(prev_key, pos, code);
            store_char(pos, code, r);
            char_total = kept;
          end
          entry_phase = ENTRY_IDLE;
          r.finished  = 1'b1;
        end
      end
      FN_PRESS: begin
        if (entry_phase != ENTRY_WAIT || k > KEY_HASH) begin
          ignored_item = 1'b1;
        end else if (k == KEY_STAR || k == KEY_HASH) begin
          entry_phase = ENTRY_IDLE;
          r.finished  = 1'b1;
        end else begin
          tap_key(k, pos, code);
          store_char(pos, code, r);
          if (char_total > lim) begin
            char_total  = char_total - 4'd1;
            entry_phase = ENTRY_IDLE;
            r.finished  = 1'b1;
          end else begin
            entry_phase = ENTRY_HELD;
          end
        end
      end
      FN_RELEASE: begin
        if (entry_phase == ENTRY_HELD) entry_phase = ENTRY_WAIT;
        else ignored_item = 1'b1;
      end
      FN_START: begin
        char_total  = '0;
        prev_key    = KEY_NONE;
        entry_phase = ENTRY_WAIT;
      end
      FN_READ: begin
        if (ri < BUFFER_DEPTH_DEF) r.read_data = text_mem[ri];
      end
      default: ignored_item = 1'b1;
    endcase
    r.display_row = (max_chars_reg != ROW0_CHARS);
    r.active      = (entry_phase != ENTRY_IDLE);
    r.char_count  = char_total;
    return r;
  endfunction

  // Event transfer with random gaps ahead of it; prediction on acceptance
  task automatic send_event(input logic [2:0] f, input logic [3:0] k, input logic [3:0] ri);
    if (!steady) begin
      while ($urandom_range(99) < 11) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    func       <= f;
    key        <= k;
    read_index <= ri;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(keypad_step(f, k, ri));
    if (!ignored_item) live_items++;
  endtask

  // Only positions already written, or beyond the buffer, are read
  function automatic logic [3:0] pick_read_index();
    logic [3:0] i;
    if (written_mask == '0 || $urandom_range(3) == 0) return 4'($urandom_range(15, 10));
    do i = 4'($urandom_range(9)); while (!written_mask[i]);
    return i;
  endfunction

  task automatic do_tick();
    send_event(FN_TICK, 4'($urandom_range(15)), 4'($urandom_range(15)));
  endtask

  task automatic do_press(input logic [3:0] k);
    send_event(FN_PRESS, k, 4'($urandom_range(15)));
  endtask

  task automatic do_key_up();
    send_event(FN_RELEASE, 4'($urandom_range(15)), 4'($urandom_range(15)));
  endtask

  task automatic do_start();
    send_event(FN_START, 4'($urandom_range(15)), 4'($urandom_range(15)));
  endtask

  task automatic do_read(input logic [3:0] idx);
    send_event(FN_READ, 4'($urandom_range(15)), idx);
  endtask

  task automatic send_noise();
    logic [2:0] f;
    f = 3'($urandom_range(7));
    send_event(f, 4'($urandom_range(15)),
               (f == FN_READ) ? pick_read_index() : 4'($urandom_range(15)));
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_CHARS) max_chars_reg = val[3:0];
    else if (idx == CFG_TIMEOUT) timeout_reg = val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [3:0] maxc, input logic [15:0] tmo);
    drain_results();
    cfg_write(CFG_MAX_CHARS, {12'd0, maxc});
    cfg_write(CFG_TIMEOUT, tmo);
  endtask

  // Events with no entry open, with reset register values
  task automatic test_idle_events();
    do_tick();
    do_press(4'd5);
    do_key_up();
    do_read(4'd12);
    do_read(4'd15);
    send_event(3'd7, 4'd14, 4'd3);
    send_event(3'd5, 4'd0, 4'd0);
  endtask

  // Letter stepping, held key, same-key timeout and full-buffer timeout
  task automatic test_multi_tap_entry();
    configure(4'd2, 16'd1);
    cfg_write(2'd2, 16'hFFFF);
    cfg_write(2'd3, 16'h5A5A);
    do_start();
    do_press(4'd9);
    do_press(4'd9);
    do_tick();
    do_key_up();
    do_press(4'd9);
    do_key_up();
    do_press(4'd12);
    do_tick();
    do_tick();
    do_press(4'd9);
    do_key_up();
    do_tick();
    do_tick();
    do_read(4'd1);
    do_read(4'd2);
  endtask

  // Overflowing press, star and hash, and a zero maximum
  task automatic test_entry_ends();
    do_start();
    do_press(4'd0);
    do_key_up();
    do_press(4'd0);
    do_key_up();
    do_press(4'd1);
    do_key_up();
    do_press(4'd2);
    do_start();
    do_press(KEY_HASH);
    do_start();
    do_press(KEY_STAR);
    configure(4'd0, 16'd1);
    do_start();
    do_press(4'd7);
    do_start();
    do_tick();
    do_tick();
    do_read(4'd0);
  endtask

  // Timeouts too long to close a character, including the largest one
  task automatic test_long_timeouts();
    configure(4'd2, TICK_SAT - 16'd1);
    steady <= 1'b1;
    do_start();
    do_press(4'd3);
    do_key_up();
    repeat (24) do_tick();
    do_press(4'd3);
    do_key_up();
    do_press(KEY_HASH);
    configure(4'd2, TICK_SAT);
    do_start();
    do_press(4'd4);
    do_key_up();
    do_press(4'd5);
    do_key_up();
    repeat (24) do_tick();
    do_press(4'd6);
    drain_results();
    steady <= 1'b0;
  endtask

  // One entry with random keys, tap counts, tick gaps and stray events
  task automatic random_entry();
    logic [3:0] k;
    int         roll, taps, gap;
    k = 4'($urandom_range(9));
    do_start();
    for (int s = 0; s < 30 && entry_phase != ENTRY_IDLE; s++) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        do_press($urandom_range(1) ? KEY_STAR : KEY_HASH);
      end else if (roll < 12) begin
        do_read(pick_read_index());
      end else if (roll < 17) begin
        send_noise();
      end else begin
        if ($urandom_range(1)) k = 4'($urandom_range(9));
        taps = $urandom_range(6, 1);
        for (int t = 0; t < taps && entry_phase != ENTRY_IDLE; t++) begin
          do_press(k);
          repeat ($urandom_range(1)) do_tick();
          do_key_up();
          gap = ($urandom_range(99) < 65) ? 0 :
                $urandom_range((timeout_reg < 8) ? timeout_reg + 2 : 3, 1);
          repeat (gap) do_tick();
        end
      end
    end
    repeat ($urandom_range(2)) do_read(pick_read_index());
  endtask

  // Phases of random entries under varied settings, extremes first
  task automatic test_random_traffic();
    logic [3:0]  maxc;
    logic [15:0] tmo;
    int          target;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin maxc = 4'd0;  tmo = 16'd2; end
        1: begin maxc = 4'd15; tmo = 16'd1; end
        2: begin maxc = 4'd10; tmo = TICK_SAT; end
        3: begin maxc = 4'd1;  tmo = 16'd3; end
        default: begin
          maxc = 4'($urandom_range(15));
          tmo  = ($urandom_range(99) < 70) ? 16'($urandom_range(6, 1)) :
                                             16'($urandom_range(65535, 1));
        end
      endcase
      configure(maxc, tmo);
      // one phase runs without any gaps or stalls
      steady <= (p == 4);
      target = live_items + RANDOM_ITEMS / PHASES;
      while (live_items < target) begin
        if ($urandom_range(9) != 0) random_entry();
        else repeat ($urandom_range(4, 1)) send_noise();
      end
    end
    drain_results();
    steady <= 1'b0;
  endtask

  // Result side back-pressure
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 11);
  end

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endfunction

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no prediction outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("char_written", want.char_written, char_written);
        check_field("char_index", want.char_index, char_index);
        check_field("char_code", want.char_code, char_code);
        check_field("display_row", want.display_row, display_row);
        check_field("active", want.active, active);
        check_field("finished", want.finished, finished);
        check_field("char_count", want.char_count, char_count);
        check_field("read_data", want.read_data, read_data);
      end
    end
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Test sequence
  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_idle_events();
    test_multi_tap_entry();
    test_entry_ends();
    test_long_timeouts();
    test_random_traffic();
    drain_results();
    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
